FILE: rtl/pvsd_pkg.sv
// Package with the decoder's mode codes, header constants and conversion functions.
`timescale 1ns / 1ps
package pvsd_pkg;
	localparam logic [15:0] EXP_DIMS_RESET = 16'd384;
	localparam logic [18:0] HDR_LEN = 19'd12;
	localparam logic [18:0] COUNT_MAX = 19'h7FFFF;
	localparam logic [7:0] MAGIC_0 = 8'h52;
	localparam logic [7:0] MAGIC_1 = 8'h56;
	localparam logic [7:0] MAGIC_2 = 8'h31;

	typedef enum logic [2:0] {
		M_PEND  = 3'd0,
		M_RAW16 = 3'd1,
		M_RAW32 = 3'd2,
		M_HDR   = 3'd3,
		M_F32   = 3'd4,
		M_F16   = 3'd5,
		M_BF16  = 3'd6,
		M_I8    = 3'd7
	} mode_t;

	// One converted element on its way to the multiply or output stage.
	typedef struct packed {
		logic        valid;
		logic        have;
		logic        done;
		logic        fail;
		logic        is_i8;
		logic [31:0] bits;
		logic [31:0] scale;
	} stage_t;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [31:0] s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] lz;
		logic [10:0] mn;
		logic [7:0] ex;
		s = {h[15], 31'd0};
		e = h[14:10];
		m = h[9:0];
		lz = 4'd0;
		for (int k = 9; k >= 0; k--) begin
			if (m[k] && lz == 4'd0) lz = 4'(10 - k);
		end
		mn = {1'b0, m} << lz;
		ex = 8'd113 - {4'd0, lz};
		if (e == 5'd0) begin
			if (m == 10'd0) return s;
			return s | {1'b0, ex, mn[9:0], 13'd0};
		end
		if (e == 5'd31)
			return s | 32'h7F800000 | {9'd0, m, 13'd0} | ((m != 10'd0) ? 32'h00400000 : 32'd0);
		return s | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
	endfunction

	// Round-to-nearest-even float32 multiply of a signed byte by a float32.
	function automatic logic [31:0] i8_mul(input logic [7:0] q, input logic [31:0] f);
		logic sq, sr;
		logic [7:0] aq;
		logic [7:0] ef;
		logic [23:0] mf;
		logic [31:0] p;
		logic [4:0] msb;
		logic signed [10:0] ee;
		logic [23:0] man;
		logic g, st;
		logic [24:0] rm;
		logic [31:0] sh;
		logic [4:0] rs;
		sq = q[7];
		aq = sq ? 8'(-q) : q;
		ef = f[30:23];
		sr = sq ^ f[31];
		mf = {ef != 8'd0, f[22:0]};
		if (ef == 8'hFF) begin
			if (f[22:0] != 23'd0) return f | 32'h00400000;
			if (aq == 8'd0) return 32'hFFC00000;
			return {sr, 31'h7F800000};
		end
		p = {24'd0, aq} * {8'd0, mf};
		if (p == 32'd0) return {sr, 31'd0};
		msb = 5'd0;
		for (int k = 0; k < 32; k++) if (p[k]) msb = 5'(k);
		// value = p * 2^(e-150), with e = max(ef,1)
		ee = 11'(signed'({3'd0, ((ef == 8'd0) ? 8'd1 : ef)})) - 11'sd150
			+ 11'(signed'({6'd0, msb})) + 11'sd127;
		if (ee >= 11'sd1) begin
			sh = (msb >= 5'd23) ? (p >> (msb - 5'd23)) : (p << (5'd23 - msb));
			man = sh[23:0];
			if (msb > 5'd23) begin
				rs = msb - 5'd23;
				g = p[rs - 5'd1];
				st = ((p & ((32'd1 << (rs - 5'd1)) - 32'd1)) != 32'd0);
			end else begin
				g = 1'b0; st = 1'b0;
			end
		end else begin
			// subnormal: shift so exponent is 1
			rs = 5'(11'sd1 - ee);
			sh = (msb >= 5'd23) ? (p >> (msb - 5'd23)) : (p << (5'd23 - msb));
			man = 24'(sh[23:0] >> rs);
			g = (msb > 5'd23 || rs != 0) ?
				((({p, 8'd0} >> (8'({3'd0, msb}) - 8'd23 + 8'({3'd0, rs}) + 8'd7)) & 40'd1) != 0)
				: 1'b0;
			st = (({p, 8'd0} & ((40'd1 << (8'({3'd0, msb}) - 8'd23 + 8'({3'd0, rs}) + 8'd7))
				- 40'd1)) != 40'd0);
			ee = 11'sd0;
		end
		rm = {1'b0, man} + {24'd0, g && (st || man[0])};
		if (ee == 11'sd0) begin
			return {sr, 8'(rm[23]), rm[22:0]};
		end
		if (rm[24]) begin
			rm = rm >> 1;
			ee = ee + 11'sd1;
		end
		if (ee >= 11'sd255) return {sr, 31'h7F800000};
		return {sr, ee[7:0], rm[22:0]};
	endfunction
endpackage

FILE: rtl/pvsd_parse.sv
// Byte parser: header check, element assembly and format conversion.
`timescale 1ns / 1ps
module pvsd_parse import pvsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [7:0]  data_byte,
	input  logic [18:0] blob_length,
	input  logic        last_byte,
	input  logic [15:0] dims,
	output stage_t      st_s1
);
	logic [18:0] cnt_q;
	mode_t mode_q;
	logic [15:0] hdims_q;
	logic [31:0] scale_q, asm_q;
	logic [7:0] held_q [3];
	logic fail_q;

	logic [18:0] i;
	logic [31:0] w, elem;
	mode_t nmode;
	logic [15:0] nhd;
	logic [31:0] nscale, nasm;
	logic nfail, have, mism, is_i8;
	logic [18:0] j, nlen;
	logic [1:0] pos, slast;

	always_comb begin
		i = cnt_q;
		nmode = mode_q; nhd = hdims_q; nscale = scale_q; nasm = asm_q;
		nfail = fail_q || (i >= blob_length);
		have = 1'b0; elem = 32'd0; is_i8 = 1'b0;
		w = 32'd0; j = 19'd0; pos = 2'd0; slast = 2'd0; nlen = 19'd0; mism = 1'b0;
		case (mode_q)
			M_PEND: begin
				mism = (i == 19'd0 && (blob_length < HDR_LEN || data_byte != MAGIC_0)) ||
					(i == 19'd1 && data_byte != MAGIC_1) ||
					(i == 19'd2 && data_byte != MAGIC_2) || i >= 19'd3;
				if (i >= 19'd3) w = {8'd0, held_q[2], held_q[1], held_q[0]};
				else if (i == 19'd2) w = {8'd0, data_byte, held_q[1], held_q[0]};
				else if (i == 19'd1) w = {16'd0, data_byte, held_q[0]};
				else w = {24'd0, data_byte};
				if (mism) begin
					if (dims == 16'd0) begin
						nfail = 1'b1; nmode = M_RAW32;
					end else if (blob_length == {2'd0, dims, 1'b0}) nmode = M_RAW16;
					else if (blob_length == {1'b0, dims, 2'b0}) nmode = M_RAW32;
					else begin
						nfail = 1'b1; nmode = M_RAW32;
					end
					if (nmode == M_RAW16 && i >= 19'd1) begin
						have = 1'b1;
						elem = half_to_single(w[15:0]);
						nasm = {24'd0, w[23:16]};
					end else nasm = w;
				end else if (i == 19'd2) nmode = M_HDR;
			end
			M_HDR: begin
				if (i == 19'd3) begin
					if (data_byte <= 8'd3) nmode = mode_t'(3'd4 + data_byte[2:0]);
					else nfail = 1'b1;
				end
			end
			default: begin
				if (mode_q >= M_F32 && i < HDR_LEN) begin
					if (i == 19'd6) nhd = {8'd0, data_byte};
					else if (i == 19'd7) begin
						nhd = {data_byte, hdims_q[7:0]};
						if (mode_q == M_F32) nlen = HDR_LEN + {1'b0, nhd, 2'b0};
						else if (mode_q == M_I8) nlen = HDR_LEN + {3'd0, nhd};
						else nlen = HDR_LEN + {2'd0, nhd, 1'b0};
						if (nhd != dims || dims == 16'd0 || blob_length != nlen) nfail = 1'b1;
					end else if (i >= 19'd8) begin
						case (i[1:0])
							2'd0: nscale[7:0] = data_byte;
							2'd1: nscale[15:8] = data_byte;
							2'd2: nscale[23:16] = data_byte;
							default: nscale[31:24] = data_byte;
						endcase
					end
				end else begin
					j = (mode_q >= M_F32) ? i - HDR_LEN : i;
					slast = (mode_q == M_RAW32 || mode_q == M_F32) ? 2'd3 :
						(mode_q == M_I8) ? 2'd0 : 2'd1;
					pos = j[1:0] & slast;
					if (pos == 2'd0) nasm = {24'd0, data_byte};
					else nasm = asm_q | ({24'd0, data_byte} << {pos, 3'd0});
					if (pos == slast) begin
						have = 1'b1;
						case (mode_q)
							M_RAW16, M_F16: elem = half_to_single(nasm[15:0]);
							M_BF16: elem = {nasm[15:0], 16'd0};
							M_I8: begin
								elem = nasm; is_i8 = 1'b1;
							end
							default: elem = nasm;
						endcase
					end
				end
			end
		endcase
		if (last_byte && (i + 19'd1 < blob_length)) nfail = 1'b1;
		if (nfail) have = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; mode_q <= M_PEND; hdims_q <= '0; scale_q <= '0;
			asm_q <= '0; fail_q <= 1'b0; st_s1 <= '0;
		end else if (adv) begin
			st_s1.valid <= have || last_byte;
			st_s1.have <= have;
			st_s1.done <= last_byte;
			st_s1.fail <= last_byte && nfail;
			st_s1.is_i8 <= is_i8;
			st_s1.bits <= have ? elem : 32'd0;
			st_s1.scale <= scale_q;
			if (last_byte) begin
				cnt_q <= '0; mode_q <= M_PEND; hdims_q <= '0; scale_q <= '0;
				asm_q <= '0; fail_q <= 1'b0;
			end else begin
				cnt_q <= (cnt_q < COUNT_MAX) ? cnt_q + 19'd1 : cnt_q;
				mode_q <= nmode; hdims_q <= nhd; scale_q <= nscale;
				asm_q <= nasm; fail_q <= nfail;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_q == M_PEND && i < 19'd3) held_q[i[1:0]] <= data_byte;
		end
	end
endmodule

FILE: rtl/pvsd_scale.sv
// Output stage: int8 dequantizing multiply into the result register.
`timescale 1ns / 1ps
module pvsd_scale import pvsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  stage_t      st_s1,
	output logic        valid_s2,
	output logic [31:0] bits_s2,
	output logic        have_s2,
	output logic        done_s2,
	output logic        fail_s2
);
	logic [31:0] prod;
	assign prod = st_s1.is_i8 ? i8_mul(st_s1.bits[7:0], st_s1.scale) : st_s1.bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv) valid_s2 <= st_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bits_s2 <= st_s1.have ? prod : 32'd0;
			have_s2 <= st_s1.have;
			done_s2 <= st_s1.done;
			fail_s2 <= st_s1.fail;
		end
	end
endmodule

FILE: rtl/packed_vector_stream_decoder_core.sv
// Top level of the packed vector stream decoder.
`timescale 1ns / 1ps
// Usage: blob bytes enter one item per cycle on in_valid/in_ready with data_byte,
// the blob's blob_length and last_byte. Results leave on out_valid/out_ready:
// element_bits with element_valid for each finished element, and blob_done with
// status on the item for the blob's final byte (status 1 means drop the blob).
// An input byte causes at most one result item.
// A byte passes a parse/convert register, then a register after the int8 scale
// multiply, before its result is offered on out_valid. The decoder takes one
// byte per cycle while the receiver does not stall the output, with a single
// parse pass per byte.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, both stages hold and in_ready stays low until that result
// is taken, even when the first stage is empty.
// Reset clears the blob state, empties the pipeline and loads the dimension
// register with 384. The user writes expected_dimensions via cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this.
module packed_vector_stream_decoder_core import pvsd_pkg::*; #(
	parameter logic [15:0] DIMS_RESET = EXP_DIMS_RESET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [18:0] blob_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] element_bits,
	output logic        element_valid,
	output logic        blob_done,
	output logic        status
);
	logic [15:0] dims_q;
	stage_t st_s1;
	logic adv, valid_s2;

	// Advance whenever the output slot is empty or being drained.
	assign adv = !valid_s2 || out_ready;
	assign in_ready = adv;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dims_q <= DIMS_RESET;
		else if (cfg_we) dims_q <= cfg_wdata;
	end

	pvsd_parse u_parse (
		.clk(clk), .arst_n(arst_n), .adv(adv && in_valid),
		.data_byte(data_byte), .blob_length(blob_length), .last_byte(last_byte),
		.dims(dims_q), .st_s1(st_s1)
	);

	stage_t st_gate;
	logic in_gap_q;
	// A cycle without an accepted byte sends an empty slot down the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_gap_q <= 1'b1;
		else if (adv) in_gap_q <= !in_valid;
	end
	always_comb begin
		st_gate = st_s1;
		if (in_gap_q) st_gate.valid = 1'b0;
	end

	pvsd_scale u_scale (
		.clk(clk), .arst_n(arst_n), .adv(adv), .st_s1(st_gate),
		.valid_s2(valid_s2), .bits_s2(element_bits), .have_s2(element_valid),
		.done_s2(blob_done), .fail_s2(status)
	);
endmodule
